// File: hw/rtl/dppa_pkg.sv
package dppa_pkg;

    // field widths
    localparam int ECHO_W      = 15;
    localparam int INTERVAL_W  = 10;
    localparam int SAMPLE_W    = 10;
    localparam int CM_W        = 9;
    localparam int LOCKOUT_W   = 8;

    localparam int ELAPSED_WIDTH_DEF = 10;

    // distance: floor(w*17/1000) == (w * DIST_MULT) >> DIST_SHIFT for w <= 30000
    localparam int MUL_A_W    = 15;
    localparam int MUL_B_W    = 24;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int DIST_W     = 10;
    localparam int DIST_SHIFT = PROD_W - DIST_W;
    localparam logic [MUL_B_W-1:0] DIST_MULT  = 24'd9126807;
    localparam logic [ECHO_W-1:0]  ECHO_LIMIT = 15'd30000;

    // interval divider: |num| < 2^19, span < 2^9
    localparam int DIV_NUM_W = 19;
    localparam int DIV_DEN_W = CM_W;

    // apb
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register reset values
    localparam logic [SAMPLE_W-1:0]   RST_SAMPLE_PERIOD = 10'd60;
    localparam logic [CM_W-1:0]       RST_NEAR_LIMIT    = 9'd2;
    localparam logic [CM_W-1:0]       RST_UPPER_FAR     = 9'd100;
    localparam logic [CM_W-1:0]       RST_LOWER_FAR     = 9'd150;
    localparam logic [INTERVAL_W-1:0] RST_FASTEST       = 10'd50;
    localparam logic [INTERVAL_W-1:0] RST_SLOWEST       = 10'd600;
    localparam logic [LOCKOUT_W-1:0]  RST_LOCKOUT       = 8'd200;

    typedef enum logic [2:0] {
        REG_SAMPLE_PERIOD,
        REG_NEAR_LIMIT,
        REG_UPPER_FAR,
        REG_LOWER_FAR,
        REG_FASTEST,
        REG_SLOWEST,
        REG_LOCKOUT
    } dppa_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   sample_period;
        logic [CM_W-1:0]       near_limit_cm;
        logic [CM_W-1:0]       upper_far_cm;
        logic [CM_W-1:0]       lower_far_cm;
        logic [INTERVAL_W-1:0] fastest_interval;
        logic [INTERVAL_W-1:0] slowest_interval;
        logic [LOCKOUT_W-1:0]  lockout_ticks;
    } dppa_cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRONT,
        S_DIST,
        S_RANGE,
        S_SCALE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_STORE,
        S_FINISH
    } dppa_state_t;

    typedef struct packed {
        logic load_in;
        logic front;
        logic mul_dist;
        logic range_chk;
        logic mul_scale;
        logic div_start;
        logic store;
        logic chan;
        logic finish;
    } dppa_cmd_t;

    typedef struct packed {
        logic sample_due;
        logic in_range;
        logic div_busy;
        logic out_free;
    } dppa_status_t;

endpackage

// File: hw/rtl/dppa_tick_if.sv
interface dppa_tick_if import dppa_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              button_level;
    logic [ECHO_W-1:0] echo_upper_us;
    logic [ECHO_W-1:0] echo_lower_us;

    modport source (
        output valid,
        output button_level,
        output echo_upper_us,
        output echo_lower_us,
        input  ready
    );

    modport sink (
        input  valid,
        input  button_level,
        input  echo_upper_us,
        input  echo_lower_us,
        output ready
    );

endinterface

// File: hw/rtl/dppa_alert_if.sv
interface dppa_alert_if import dppa_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic                  motor_on;
    logic                  buzzer_on;
    logic                  system_on;
    logic [INTERVAL_W-1:0] motor_interval;
    logic [INTERVAL_W-1:0] buzzer_interval;

    modport source (
        output valid,
        output motor_on,
        output buzzer_on,
        output system_on,
        output motor_interval,
        output buzzer_interval,
        input  ready
    );

    modport sink (
        input  valid,
        input  motor_on,
        input  buzzer_on,
        input  system_on,
        input  motor_interval,
        input  buzzer_interval,
        output ready
    );

endinterface

// File: hw/rtl/dppa_cfg.sv
module dppa_cfg import dppa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output dppa_cfg_t             cfg
);

    dppa_cfg_t cfg_reg;
    logic      wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_period    <= RST_SAMPLE_PERIOD;
            cfg_reg.near_limit_cm    <= RST_NEAR_LIMIT;
            cfg_reg.upper_far_cm     <= RST_UPPER_FAR;
            cfg_reg.lower_far_cm     <= RST_LOWER_FAR;
            cfg_reg.fastest_interval <= RST_FASTEST;
            cfg_reg.slowest_interval <= RST_SLOWEST;
            cfg_reg.lockout_ticks    <= RST_LOCKOUT;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SAMPLE_PERIOD: cfg_reg.sample_period    <= pwdata[SAMPLE_W-1:0];
                REG_NEAR_LIMIT:    cfg_reg.near_limit_cm    <= pwdata[CM_W-1:0];
                REG_UPPER_FAR:     cfg_reg.upper_far_cm     <= pwdata[CM_W-1:0];
                REG_LOWER_FAR:     cfg_reg.lower_far_cm     <= pwdata[CM_W-1:0];
                REG_FASTEST:       cfg_reg.fastest_interval <= pwdata[INTERVAL_W-1:0];
                REG_SLOWEST:       cfg_reg.slowest_interval <= pwdata[INTERVAL_W-1:0];
                REG_LOCKOUT:       cfg_reg.lockout_ticks    <= pwdata[LOCKOUT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SAMPLE_PERIOD: prdata = APB_DATA_W'(cfg_reg.sample_period);
            REG_NEAR_LIMIT:    prdata = APB_DATA_W'(cfg_reg.near_limit_cm);
            REG_UPPER_FAR:     prdata = APB_DATA_W'(cfg_reg.upper_far_cm);
            REG_LOWER_FAR:     prdata = APB_DATA_W'(cfg_reg.lower_far_cm);
            REG_FASTEST:       prdata = APB_DATA_W'(cfg_reg.fastest_interval);
            REG_SLOWEST:       prdata = APB_DATA_W'(cfg_reg.slowest_interval);
            REG_LOCKOUT:       prdata = APB_DATA_W'(cfg_reg.lockout_ticks);
            default:           prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/dppa_div.sv
module dppa_div import dppa_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    output logic                 busy,
    output logic [DIV_NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   trial_sub;
    logic                 fits;
    logic [DIV_DEN_W-1:0] rem_next;

    // restoring division, one quotient bit per cycle
    assign trial     = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = trial >= {1'b0, den_reg};
    assign rem_next  = fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

endmodule

// File: hw/rtl/dppa_dp.sv
module dppa_dp import dppa_pkg::*; #(
    parameter int ELAPSED_WIDTH = ELAPSED_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dppa_cmd_t             cmd,
    output dppa_status_t          status,
    input  dppa_cfg_t             cfg,
    input  logic                  button_level,
    input  logic [ECHO_W-1:0]     echo_upper_us,
    input  logic [ECHO_W-1:0]     echo_lower_us,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  motor_on,
    output logic                  buzzer_on,
    output logic                  system_on,
    output logic [INTERVAL_W-1:0] motor_interval,
    output logic [INTERVAL_W-1:0] buzzer_interval
);

    // latched tick
    logic              button_reg;
    logic [ECHO_W-1:0] echo_up_reg;
    logic [ECHO_W-1:0] echo_lo_reg;

    // block state
    logic                     active_reg;
    logic                     prev_button_reg;
    logic [LOCKOUT_W-1:0]     lockout_reg;
    logic                     main_reg;
    logic [ELAPSED_WIDTH-1:0] sample_el_reg;
    logic [ELAPSED_WIDTH-1:0] motor_el_reg;
    logic [ELAPSED_WIDTH-1:0] buzzer_el_reg;
    logic [INTERVAL_W-1:0]    motor_per_reg;
    logic [INTERVAL_W-1:0]    buzzer_per_reg;
    logic                     motor_ph_reg;
    logic                     buzzer_ph_reg;

    // arithmetic
    logic [PROD_W-1:0]  prod_reg;
    logic [CM_W-1:0]    diff_reg;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;

    // result register
    logic                  out_valid_reg;
    logic                  out_motor_reg;
    logic                  out_buzzer_reg;
    logic                  out_system_reg;
    logic [INTERVAL_W-1:0] out_motor_int_reg;
    logic [INTERVAL_W-1:0] out_buzzer_int_reg;

    // front-end decode
    logic locked;
    logic press;
    logic active_next;
    logic sample_due;

    // per-channel mapping
    logic [ECHO_W-1:0]     w_sel;
    logic [CM_W-1:0]       far_sel;
    logic [DIST_W-1:0]     dist_cm;
    logic [DIST_W-1:0]     diff_full;
    logic                  w_ok;
    logic                  in_range;
    logic                  delta_neg;
    logic [INTERVAL_W-1:0] abs_delta;
    logic [CM_W:0]         span_full;
    logic                  div_busy;
    logic [DIV_NUM_W-1:0]  quot;
    logic [INTERVAL_W+1:0] mapped;
    logic [INTERVAL_W-1:0] mapped_per;

    // end-of-tick update
    logic                     run;
    logic                     quiet;
    logic                     motor_fire;
    logic                     buzzer_fire;
    logic                     motor_ph_next;
    logic                     buzzer_ph_next;
    logic [ELAPSED_WIDTH-1:0] motor_el_mid;
    logic [ELAPSED_WIDTH-1:0] buzzer_el_mid;
    logic [ELAPSED_WIDTH-1:0] sample_el_next;
    logic [ELAPSED_WIDTH-1:0] motor_el_next;
    logic [ELAPSED_WIDTH-1:0] buzzer_el_next;

    assign locked      = lockout_reg != '0;
    assign press       = !button_reg && prev_button_reg;
    assign active_next = (!locked && press) ? !active_reg : active_reg;
    assign sample_due  = !locked && active_next &&
                         (sample_el_reg >= ELAPSED_WIDTH'(cfg.sample_period));

    assign w_sel     = cmd.chan ? echo_lo_reg : echo_up_reg;
    assign far_sel   = cmd.chan ? cfg.lower_far_cm : cfg.upper_far_cm;
    assign dist_cm   = prod_reg[DIST_SHIFT +: DIST_W];
    assign diff_full = dist_cm - {1'b0, cfg.near_limit_cm};
    assign w_ok      = (w_sel != '0) && (w_sel <= ECHO_LIMIT);
    assign in_range  = w_ok && (dist_cm > {1'b0, cfg.near_limit_cm}) &&
                       (dist_cm <= {1'b0, far_sel});

    assign delta_neg = cfg.slowest_interval < cfg.fastest_interval;
    assign abs_delta = delta_neg ? cfg.fastest_interval - cfg.slowest_interval
                                 : cfg.slowest_interval - cfg.fastest_interval;
    assign span_full = {1'b0, far_sel} - {1'b0, cfg.near_limit_cm};

    // one multiplier: echo width times the cm constant, then offset times slope
    assign mul_a = cmd.mul_scale ? MUL_A_W'(diff_reg) : w_sel;
    assign mul_b = cmd.mul_scale ? MUL_B_W'(abs_delta) : DIST_MULT;

    dppa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg[DIV_NUM_W-1:0]),
        .divisor  (span_full[CM_W-1:0]),
        .busy     (div_busy),
        .quotient (quot)
    );

    // quotient magnitude never exceeds the slope, so the sum stays in range
    always_comb
    begin
        if (delta_neg)
        begin
            mapped = {2'b00, cfg.fastest_interval} - {2'b00, quot[INTERVAL_W-1:0]};
        end
        else
        begin
            mapped = {2'b00, cfg.fastest_interval} + {2'b00, quot[INTERVAL_W-1:0]};
        end
        mapped_per = mapped[INTERVAL_W+1] ? '0 : mapped[INTERVAL_W-1:0];
    end

    assign run   = main_reg && active_reg;
    assign quiet = main_reg && !active_reg;

    assign motor_fire  = run && (motor_per_reg != '0) &&
                         (motor_el_reg >= ELAPSED_WIDTH'(motor_per_reg));
    assign buzzer_fire = run && (buzzer_per_reg != '0) &&
                         (buzzer_el_reg >= ELAPSED_WIDTH'(buzzer_per_reg));

    always_comb
    begin
        if (quiet || (run && motor_per_reg == '0))
        begin
            motor_ph_next = 1'b0;
        end
        else
        begin
            motor_ph_next = motor_fire ? !motor_ph_reg : motor_ph_reg;
        end
        if (quiet || (run && buzzer_per_reg == '0))
        begin
            buzzer_ph_next = 1'b0;
        end
        else
        begin
            buzzer_ph_next = buzzer_fire ? !buzzer_ph_reg : buzzer_ph_reg;
        end
        motor_el_mid  = motor_fire ? '0 : motor_el_reg;
        buzzer_el_mid = buzzer_fire ? '0 : buzzer_el_reg;
        // saturating increments
        sample_el_next = (&sample_el_reg) ? sample_el_reg : sample_el_reg + 1'b1;
        motor_el_next  = (&motor_el_mid) ? motor_el_mid : motor_el_mid + 1'b1;
        buzzer_el_next = (&buzzer_el_mid) ? buzzer_el_mid : buzzer_el_mid + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            button_reg  <= button_level;
            echo_up_reg <= echo_upper_us;
            echo_lo_reg <= echo_lower_us;
        end
        if (cmd.mul_dist || cmd.mul_scale)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.range_chk)
        begin
            diff_reg <= diff_full[CM_W-1:0];
        end
        if (cmd.finish)
        begin
            out_motor_reg      <= motor_ph_next;
            out_buzzer_reg     <= buzzer_ph_next;
            out_system_reg     <= active_reg;
            out_motor_int_reg  <= motor_per_reg;
            out_buzzer_int_reg <= buzzer_per_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b1;
            prev_button_reg <= 1'b1;
            lockout_reg     <= '0;
            main_reg        <= 1'b0;
            sample_el_reg   <= '0;
            motor_el_reg    <= '0;
            buzzer_el_reg   <= '0;
            motor_per_reg   <= '0;
            buzzer_per_reg  <= '0;
            motor_ph_reg    <= 1'b0;
            buzzer_ph_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.front)
            begin
                if (locked)
                begin
                    lockout_reg <= lockout_reg - 1'b1;
                    main_reg    <= 1'b0;
                end
                else
                begin
                    if (press)
                    begin
                        lockout_reg <= cfg.lockout_ticks;
                    end
                    prev_button_reg <= button_reg;
                    active_reg      <= active_next;
                    main_reg        <= 1'b1;
                end
                if (sample_due)
                begin
                    sample_el_reg <= '0;
                end
            end

            // an out-of-range distance turns the channel off
            if (cmd.range_chk && !in_range)
            begin
                if (cmd.chan)
                begin
                    buzzer_per_reg <= '0;
                end
                else
                begin
                    motor_per_reg <= '0;
                end
            end
            if (cmd.store)
            begin
                if (cmd.chan)
                begin
                    buzzer_per_reg <= mapped_per;
                end
                else
                begin
                    motor_per_reg <= mapped_per;
                end
            end

            if (cmd.finish)
            begin
                motor_ph_reg  <= motor_ph_next;
                buzzer_ph_reg <= buzzer_ph_next;
                sample_el_reg <= sample_el_next;
                motor_el_reg  <= motor_el_next;
                buzzer_el_reg <= buzzer_el_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.sample_due = sample_due;
    assign status.in_range   = in_range;
    assign status.div_busy   = div_busy;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign motor_on        = out_motor_reg;
    assign buzzer_on       = out_buzzer_reg;
    assign system_on       = out_system_reg;
    assign motor_interval  = out_motor_int_reg;
    assign buzzer_interval = out_buzzer_int_reg;

endmodule

// File: hw/rtl/dppa_ctrl.sv
module dppa_ctrl import dppa_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  dppa_status_t status,
    output dppa_cmd_t    cmd
);

    dppa_state_t state_reg;
    dppa_state_t state_next;
    logic        chan_reg;
    logic        chan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.chan   = chan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_FRONT;
                end
            end
            S_FRONT:
            begin
                cmd.front  = 1'b1;
                chan_next  = 1'b0;
                state_next = status.sample_due ? S_DIST : S_FINISH;
            end
            S_DIST:
            begin
                cmd.mul_dist = 1'b1;
                state_next   = S_RANGE;
            end
            S_RANGE:
            begin
                cmd.range_chk = 1'b1;
                if (status.in_range)
                begin
                    state_next = S_SCALE;
                end
                else if (chan_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    chan_next  = 1'b1;
                    state_next = S_DIST;
                end
            end
            S_SCALE:
            begin
                cmd.mul_scale = 1'b1;
                state_next    = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if (chan_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    chan_next  = 1'b1;
                    state_next = S_DIST;
                end
            end
            S_FINISH:
            begin
                // hold the result until the output register can take it
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept_to_front: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_FRONT))
        else $error("accepted tick did not start the front stage");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result written while output register still full");

    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_store_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE) |-> ($past(state_reg) == S_DIV_WAIT && !status.div_busy))
        else $error("interval stored before the divider finished");

endmodule

// File: hw/rtl/dual_proximity_pulse_alert.sv
// a plain tick passes from idle through the front stage to the finish state, and a
// new tick is taken only back in idle, once the result is in the output register
// a sampling tick runs both channels through the shared multiplier and the
// 19-step divider; a channel out of range skips the scaling and the division,
// and a full output register holds the result in the finish state
// async active-low reset loads the register defaults, active on, all channels off
module dual_proximity_pulse_alert import dppa_pkg::*; #(
    parameter int ELAPSED_WIDTH = ELAPSED_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dppa_tick_if.sink             tick,
    dppa_alert_if.source          alert,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    dppa_cfg_t    cfg;
    dppa_cmd_t    cmd;
    dppa_status_t status;

    dppa_cfg_t cfg_unused_guard;
    assign cfg_unused_guard = cfg;

    dppa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dppa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tick.valid),
        .in_ready (tick.ready),
        .status   (status),
        .cmd      (cmd)
    );

    dppa_dp #(
        .ELAPSED_WIDTH (ELAPSED_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg             (cfg_unused_guard),
        .button_level    (tick.button_level),
        .echo_upper_us   (tick.echo_upper_us),
        .echo_lower_us   (tick.echo_lower_us),
        .out_valid       (alert.valid),
        .out_ready       (alert.ready),
        .motor_on        (alert.motor_on),
        .buzzer_on       (alert.buzzer_on),
        .system_on       (alert.system_on),
        .motor_interval  (alert.motor_interval),
        .buzzer_interval (alert.buzzer_interval)
    );

endmodule
